FILE: rtl/gsma_pkg.sv
package gsma_pkg;

   // fixed field widths
   localparam int SIZE_W     = 9;
   localparam int CENTER_W   = 12;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 12;
   localparam int ACC_W      = 64;
   localparam int DIAG_W     = 63;

   // parameter defaults
   localparam int DEF_MAX_EXTENT  = 256;
   localparam int DEF_WEIGHT_BITS = 16;
   localparam int DEF_FRAC_BITS   = 4;

   localparam logic [SIZE_W-1:0]   SIZE_RESET   = SIZE_W'(256);
   localparam logic [CENTER_W-1:0] CENTER_RESET = '0;

   localparam logic [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
   localparam logic [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SIZE_X   = 3'd0,
      CSR_SIZE_Y   = 3'd1,
      CSR_SIZE_Z   = 3'd2,
      CSR_CENTER_X = 3'd3,
      CSR_CENTER_Y = 3'd4,
      CSR_CENTER_Z = 3'd5
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MUL_A,
      ST_MUL_B,
      ST_ACC
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic load;
      logic mul_a;
      logic mul_b;
      logic acc;
      logic emit;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic last;
   } sts_type;

   // signed add that clamps at the 64-bit limits
   function automatic logic signed [ACC_W-1:0] sat_add(
      input logic signed [ACC_W-1:0] a,
      input logic signed [ACC_W-1:0] b
   );
      logic [ACC_W:0] s;
      s = {a[ACC_W-1], a} + {b[ACC_W-1], b};
      if (s[ACC_W] != s[ACC_W-1]) begin
         return s[ACC_W] ? $signed(ACC_MIN) : $signed(ACC_MAX);
      end
      return $signed(s[ACC_W-1:0]);
   endfunction

endpackage

FILE: rtl/gsma_if.sv
interface gsma_req_if #(
   parameter int WEIGHT_W = gsma_pkg::DEF_WEIGHT_BITS
);
   logic                valid;
   logic                ready;
   logic [WEIGHT_W-1:0] weight;

   modport source (output valid, output weight, input ready);
   modport sink   (input valid, input weight, output ready);
endinterface

interface gsma_rsp_if;
   import gsma_pkg::*;
   logic                     valid;
   logic                     ready;
   logic [DIAG_W-1:0]        sum_xx;
   logic [DIAG_W-1:0]        sum_yy;
   logic [DIAG_W-1:0]        sum_zz;
   logic signed [ACC_W-1:0]  sum_xy;
   logic signed [ACC_W-1:0]  sum_xz;
   logic signed [ACC_W-1:0]  sum_yz;

   modport source (output valid, output sum_xx, output sum_yy, output sum_zz,
                   output sum_xy, output sum_xz, output sum_yz, input ready);
   modport sink   (input valid, input sum_xx, input sum_yy, input sum_zz,
                   input sum_xy, input sum_xz, input sum_yz, output ready);
endinterface

interface gsma_csr_if;
   import gsma_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: rtl/gsma_ctrl.sv
module gsma_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output gsma_pkg::cmd_type cmd,
   input  gsma_pkg::sts_type sts
);
   import gsma_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_MUL_A;
            end
         end
         ST_MUL_A: begin
            cmd.mul_a = 1'b1;
            state_in  = ST_MUL_B;
         end
         ST_MUL_B: begin
            cmd.mul_b = 1'b1;
            state_in  = ST_ACC;
         end
         ST_ACC: begin
            if (!sts.last) begin
               cmd.acc  = 1'b1;
               state_in = ST_IDLE;
            end else if (!rsp_valid_ff || rsp_ready) begin
               // output register free: hand over the tensor
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

FILE: rtl/gsma_datapath.sv
module gsma_datapath #(
   parameter int MAX_EXTENT  = gsma_pkg::DEF_MAX_EXTENT,
   parameter int WEIGHT_BITS = gsma_pkg::DEF_WEIGHT_BITS,
   parameter int FRAC_BITS   = gsma_pkg::DEF_FRAC_BITS
) (
   input  logic                             clock,
   input  logic                             reset,
   input  gsma_pkg::cmd_type                cmd,
   output gsma_pkg::sts_type                sts,
   input  logic [WEIGHT_BITS-1:0]           weight,
   input  logic                             csr_we,
   input  logic [gsma_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [gsma_pkg::CSR_DATA_W-1:0]  csr_data,
   output logic [gsma_pkg::DIAG_W-1:0]      sum_xx,
   output logic [gsma_pkg::DIAG_W-1:0]      sum_yy,
   output logic [gsma_pkg::DIAG_W-1:0]      sum_zz,
   output logic signed [gsma_pkg::ACC_W-1:0] sum_xy,
   output logic signed [gsma_pkg::ACC_W-1:0] sum_xz,
   output logic signed [gsma_pkg::ACC_W-1:0] sum_yz
);
   import gsma_pkg::*;

   localparam int POS_W  = $clog2(MAX_EXTENT);
   localparam int EXT_MW = $clog2(MAX_EXTENT + 1);
   localparam int EXT_W  = (EXT_MW > SIZE_W) ? EXT_MW : SIZE_W;
   localparam int OFS_MW = POS_W + FRAC_BITS;
   localparam int DW     = ((OFS_MW > CENTER_W) ? OFS_MW : CENTER_W) + 1;
   localparam int PW     = 2 * DW;
   localparam int TW     = PW + WEIGHT_BITS + 1;
   localparam int NSUM   = 6;

   function automatic logic [EXT_W-1:0] extent(input logic [SIZE_W-1:0] s);
      logic [EXT_W-1:0] se;
      se = EXT_W'(s);
      if (s == '0) begin
         return EXT_W'(1);
      end else if (se > EXT_W'(MAX_EXTENT)) begin
         return EXT_W'(MAX_EXTENT);
      end
      return se;
   endfunction

   // configuration
   logic [SIZE_W-1:0]   size_x_ff, size_y_ff, size_z_ff;
   logic [CENTER_W-1:0] center_x_ff, center_y_ff, center_z_ff;

   // voxel counters
   logic [POS_W-1:0] pos_x_ff, pos_y_ff, pos_z_ff;
   logic [POS_W-1:0] pos_x_in, pos_y_in, pos_z_in;
   logic [EXT_W-1:0] ext_x, ext_y, ext_z;
   logic             last_x, last_y, last_z;

   // stage registers
   logic signed [DW-1:0]    dx_ff, dy_ff, dz_ff;
   logic signed [DW-1:0]    dx_in, dy_in, dz_in;
   logic [WEIGHT_BITS-1:0]  w_ff;
   logic                    last_ff;
   logic signed [PW-1:0]    prod_ff [NSUM];
   logic signed [TW-1:0]    term_ff [NSUM];
   logic signed [ACC_W-1:0] acc_ff  [NSUM];
   logic signed [ACC_W-1:0] acc_in  [NSUM];
   logic signed [ACC_W-1:0] out_ff  [NSUM];

   always_ff @(posedge clock) begin
      if (reset) begin
         size_x_ff   <= SIZE_RESET;
         size_y_ff   <= SIZE_RESET;
         size_z_ff   <= SIZE_RESET;
         center_x_ff <= CENTER_RESET;
         center_y_ff <= CENTER_RESET;
         center_z_ff <= CENTER_RESET;
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_SIZE_X:   size_x_ff   <= csr_data[SIZE_W-1:0];
            CSR_SIZE_Y:   size_y_ff   <= csr_data[SIZE_W-1:0];
            CSR_SIZE_Z:   size_z_ff   <= csr_data[SIZE_W-1:0];
            CSR_CENTER_X: center_x_ff <= csr_data[CENTER_W-1:0];
            CSR_CENTER_Y: center_y_ff <= csr_data[CENTER_W-1:0];
            CSR_CENTER_Z: center_z_ff <= csr_data[CENTER_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // position of this voxel and the step to the next one
   always_comb begin
      ext_x  = extent(size_x_ff);
      ext_y  = extent(size_y_ff);
      ext_z  = extent(size_z_ff);
      last_x = (EXT_W'(pos_x_ff) + EXT_W'(1)) >= ext_x;
      last_y = (EXT_W'(pos_y_ff) + EXT_W'(1)) >= ext_y;
      last_z = (EXT_W'(pos_z_ff) + EXT_W'(1)) >= ext_z;

      pos_x_in = pos_x_ff;
      pos_y_in = pos_y_ff;
      pos_z_in = pos_z_ff;
      if (!last_z) begin
         pos_z_in = pos_z_ff + POS_W'(1);
      end else begin
         pos_z_in = '0;
         if (!last_y) begin
            pos_y_in = pos_y_ff + POS_W'(1);
         end else begin
            pos_y_in = '0;
            if (!last_x) begin
               pos_x_in = pos_x_ff + POS_W'(1);
            end else begin
               pos_x_in = '0;
            end
         end
      end

      dx_in = $signed(DW'(pos_x_ff) << FRAC_BITS) - $signed(DW'(center_x_ff));
      dy_in = $signed(DW'(pos_y_ff) << FRAC_BITS) - $signed(DW'(center_y_ff));
      dz_in = $signed(DW'(pos_z_ff) << FRAC_BITS) - $signed(DW'(center_z_ff));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_x_ff <= '0;
         pos_y_ff <= '0;
         pos_z_ff <= '0;
      end else if (cmd.load) begin
         pos_x_ff <= pos_x_in;
         pos_y_ff <= pos_y_in;
         pos_z_ff <= pos_z_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         dx_ff   <= dx_in;
         dy_ff   <= dy_in;
         dz_ff   <= dz_in;
         w_ff    <= weight;
         last_ff <= last_x && last_y && last_z;
      end
   end

   // offset products: xx, yy, zz, xy, xz, yz
   always_ff @(posedge clock) begin
      if (cmd.mul_a) begin
         prod_ff[0] <= dx_ff * dx_ff;
         prod_ff[1] <= dy_ff * dy_ff;
         prod_ff[2] <= dz_ff * dz_ff;
         prod_ff[3] <= dx_ff * dy_ff;
         prod_ff[4] <= dx_ff * dz_ff;
         prod_ff[5] <= dy_ff * dz_ff;
      end
   end

   // weighting
   always_ff @(posedge clock) begin
      if (cmd.mul_b) begin
         for (int i = 0; i < NSUM; i++) begin
            term_ff[i] <= prod_ff[i] * $signed({1'b0, w_ff});
         end
      end
   end

   always_comb begin
      for (int i = 0; i < NSUM; i++) begin
         acc_in[i] = sat_add(acc_ff[i], ACC_W'(term_ff[i]));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NSUM; i++) begin
            acc_ff[i] <= '0;
         end
      end else if (cmd.emit) begin
         for (int i = 0; i < NSUM; i++) begin
            acc_ff[i] <= '0;
         end
      end else if (cmd.acc) begin
         for (int i = 0; i < NSUM; i++) begin
            acc_ff[i] <= acc_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         for (int i = 0; i < NSUM; i++) begin
            out_ff[i] <= acc_in[i];
         end
      end
   end

   assign sts.last = last_ff;

   // diagonal sums never go negative
   assign sum_xx = out_ff[0][DIAG_W-1:0];
   assign sum_yy = out_ff[1][DIAG_W-1:0];
   assign sum_zz = out_ff[2][DIAG_W-1:0];
   assign sum_xy = out_ff[3];
   assign sum_xz = out_ff[4];
   assign sum_yz = out_ff[5];

endmodule

FILE: rtl/grid_second_moment_accumulator_top.sv
// result: valid once the last voxel's word is through product, weighting and accumulate,
//   later only while the previous result still sits unread in the output register
// flow: the controller walks each voxel word through offset, product, weighting and
//   accumulate stages one at a time, taking no new word until the last one is done
// reset: sizes 256, centers 0, voxel counters and all six sums cleared, no result pending
module grid_second_moment_accumulator_top #(
   parameter int MAX_EXTENT  = gsma_pkg::DEF_MAX_EXTENT,
   parameter int WEIGHT_BITS = gsma_pkg::DEF_WEIGHT_BITS,
   parameter int FRAC_BITS   = gsma_pkg::DEF_FRAC_BITS
) (
   input logic        clock,
   input logic        reset,
   gsma_req_if.sink   req_bus,
   gsma_rsp_if.source rsp_bus,
   gsma_csr_if.sink   csr_bus
);
   import gsma_pkg::*;

   cmd_type cmd;
   sts_type sts;

   // register writes always taken; user must write only while idle, unenforced by block
   assign csr_bus.ready = 1'b1;

   // sequencer: idle -> offset products -> weighting -> accumulate / emit
   gsma_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .cmd       (cmd),
      .sts       (sts)
   );

   // counters, config registers, multipliers, saturating sums, output register
   gsma_datapath #(
      .MAX_EXTENT  (MAX_EXTENT),
      .WEIGHT_BITS (WEIGHT_BITS),
      .FRAC_BITS   (FRAC_BITS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .sts       (sts),
      .weight    (req_bus.weight),
      .csr_we    (csr_bus.valid),
      .csr_index (csr_bus.index),
      .csr_data  (csr_bus.data),
      .sum_xx    (rsp_bus.sum_xx),
      .sum_yy    (rsp_bus.sum_yy),
      .sum_zz    (rsp_bus.sum_zz),
      .sum_xy    (rsp_bus.sum_xy),
      .sum_xz    (rsp_bus.sum_xz),
      .sum_yz    (rsp_bus.sum_yz)
   );

endmodule

FILE: rtl/gsma_checker.sv
module gsma_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_ready,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic [gsma_pkg::DIAG_W-1:0]       sum_xx,
   input logic [gsma_pkg::DIAG_W-1:0]       sum_yy,
   input logic [gsma_pkg::DIAG_W-1:0]       sum_zz,
   input logic signed [gsma_pkg::ACC_W-1:0] sum_xy,
   input logic signed [gsma_pkg::ACC_W-1:0] sum_xz,
   input logic signed [gsma_pkg::ACC_W-1:0] sum_yz
);
   import gsma_pkg::*;

   // one voxel in flight at a time
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("input taken again right after a word was accepted");

   // a result only appears after the accumulate step, never straight from idle
   a_result_from_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(!req_ready))
      else $error("result appeared while the block was idle");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped before it was taken");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(sum_xx) && $stable(sum_yy) && $stable(sum_zz)
         && $stable(sum_xy) && $stable(sum_xz) && $stable(sum_yz))
      else $error("stalled result changed");

endmodule

bind grid_second_moment_accumulator_top gsma_checker u_gsma_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_bus.valid),
   .req_ready (req_bus.ready),
   .rsp_valid (rsp_bus.valid),
   .rsp_ready (rsp_bus.ready),
   .sum_xx    (rsp_bus.sum_xx),
   .sum_yy    (rsp_bus.sum_yy),
   .sum_zz    (rsp_bus.sum_zz),
   .sum_xy    (rsp_bus.sum_xy),
   .sum_xz    (rsp_bus.sum_xz),
   .sum_yz    (rsp_bus.sum_yz)
);
